### rtl/core/qph_pkg.sv
package qph_pkg;

  localparam int SZ_W   = 11;
  localparam int SLOT_W = 10;
  localparam int HASH_W = 32;
  localparam int DATA_W = 32;
  localparam int ENT_W  = 2 * SZ_W + 2 * DATA_W;

  localparam logic CFG_TABLE_SIZE = 1'b0;
  localparam logic CFG_KEY_STORE  = 1'b1;

  localparam logic [SZ_W-1:0] CNT_MAX = '1;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_CLR,
    B_IDLE,
    B_RD,
    B_CHK,
    B_FIN
  } back_state_t;

endpackage

### rtl/core/qph_fifo.sv
module qph_fifo #(
  parameter int W = 86
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);
  logic [W-1:0] mem [2];
  logic         wptr;
  logic         rptr;
  logic [1:0]   count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push && !full) begin
        wptr <= ~wptr;
      end
      if (pop && !empty) begin
        rptr <= ~rptr;
      end
      count <= count + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
    end
  end
endmodule

### rtl/core/qph_front.sv
module qph_front #(
  parameter int CAPACITY = 1024
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      clearing,
  input  logic [qph_pkg::SZ_W-1:0]  table_size,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [31:0]               hash_value,
  input  logic [31:0]               item_key,
  input  logic [31:0]               item_value,
  output logic                      push,
  output logic [qph_pkg::ENT_W-1:0] entry,
  input  logic                      full
);
  import qph_pkg::*;

  front_state_t      state, state_next;
  logic [HASH_W-1:0] hash;
  logic [DATA_W-1:0] key;
  logic [DATA_W-1:0] value;
  logic [SZ_W-1:0]   size;
  logic [SZ_W-1:0]   rem;
  logic [5:0]        step;
  logic [SZ_W-1:0]   eff_size;
  logic [SZ_W:0]     trial;
  logic [SZ_W:0]     trial_sub;

  always_comb begin
    if (int'(table_size) > CAPACITY) begin
      eff_size = SZ_W'(CAPACITY);
    end else if (table_size == '0) begin
      eff_size = SZ_W'(1);
    end else begin
      eff_size = table_size;
    end
  end

  assign trial     = {rem, hash[HASH_W-1]};
  assign trial_sub = trial - {1'b0, size};

  assign in_stall = (state != F_IDLE) || clearing;
  assign push     = (state == F_PUSH) && !full;
  assign entry    = {size, rem, key, value};

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: if (in_valid && !in_stall) state_next = F_DIV;
      F_DIV:  if (step == 6'(HASH_W - 1)) state_next = F_PUSH;
      F_PUSH: if (!full) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && in_valid && !in_stall) begin
      hash  <= hash_value;
      key   <= item_key;
      value <= item_value;
      size  <= eff_size;
      rem   <= '0;
      step  <= '0;
    end else if (state == F_DIV) begin
      rem   <= (trial >= {1'b0, size}) ? trial_sub[SZ_W-1:0] : trial[SZ_W-1:0];
      hash  <= {hash[HASH_W-2:0], 1'b0};
      step  <= step + 6'd1;
    end
  end
endmodule

### rtl/core/qph_back.sv
module qph_back #(
  parameter int CAPACITY    = 1024,
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  output logic                        clearing,
  input  logic                        key_store_en,
  input  logic [qph_pkg::ENT_W-1:0]   entry,
  input  logic                        empty,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        placed,
  output logic [qph_pkg::SLOT_W-1:0]  slot_index,
  output logic [qph_pkg::SZ_W-1:0]    stored_count
);
  import qph_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic                   full_mem [CAPACITY];
  logic [KEY_WIDTH-1:0]   key_mem  [CAPACITY];
  logic [VALUE_WIDTH-1:0] val_mem  [CAPACITY];

  back_state_t       state, state_next;
  logic [AW-1:0]     clr_addr;
  logic [SZ_W-1:0]   size;
  logic [SZ_W-1:0]   pos;
  logic [SZ_W-1:0]   i;
  logic [SZ_W-1:0]   probes;
  logic [DATA_W-1:0] key;
  logic [DATA_W-1:0] value;
  logic              found;
  logic              rd_full;
  logic [SZ_W-1:0]   count;
  logic [SZ_W+1:0]   pos_sum;
  logic [SZ_W+1:0]   pos_wrap;
  logic [SZ_W:0]     size_p1;
  logic              fin_go;

  assign clearing = (state == B_CLR);
  assign pop      = (state == B_IDLE) && !empty;
  assign fin_go   = (state == B_FIN) && (!out_valid || !out_stall);
  assign size_p1  = {1'b0, entry[ENT_W-1 -: SZ_W]} + (SZ_W+1)'(1);
  assign pos_sum  = {2'b0, pos} + {1'b0, i, 1'b1};
  assign pos_wrap = pos_sum - {2'b0, size};

  always_comb begin
    state_next = state;
    case (state)
      B_CLR:  if (clr_addr == AW'(CAPACITY - 1)) state_next = B_IDLE;
      B_IDLE: if (!empty) state_next = B_RD;
      B_RD:   state_next = B_CHK;
      B_CHK:  begin
        if (!rd_full || (i + SZ_W'(1) == probes)) begin
          state_next = B_FIN;
        end else begin
          state_next = B_RD;
        end
      end
      B_FIN:  if (fin_go) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_CLR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == B_CLR) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_CLR) begin
      full_mem[clr_addr] <= 1'b0;
    end else if (fin_go && found) begin
      full_mem[AW'(pos)] <= 1'b1;
    end
    rd_full <= full_mem[AW'(pos)];
  end

  always_ff @(posedge clk) begin
    if (fin_go && found) begin
      val_mem[AW'(pos)] <= VALUE_WIDTH'(value);
      if (key_store_en) begin
        key_mem[AW'(pos)] <= KEY_WIDTH'(key);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      size   <= entry[ENT_W-1 -: SZ_W];
      pos    <= entry[ENT_W-SZ_W-1 -: SZ_W];
      key    <= entry[2*DATA_W-1 -: DATA_W];
      value  <= entry[DATA_W-1:0];
      probes <= size_p1[SZ_W:1];
      i      <= '0;
    end else if (state == B_CHK) begin
      found <= !rd_full;
      if (rd_full && (i + SZ_W'(1) != probes)) begin
        pos <= (pos_sum >= {2'b0, size}) ? pos_wrap[SZ_W-1:0] : pos_sum[SZ_W-1:0];
        i   <= i + SZ_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      count     <= '0;
    end else begin
      if (fin_go) begin
        out_valid <= 1'b1;
        if (found && count != CNT_MAX) begin
          count <= count + SZ_W'(1);
        end
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      placed       <= found;
      slot_index   <= found ? SLOT_W'(pos) : '0;
      stored_count <= (found && count != CNT_MAX) ? count + SZ_W'(1) : count;
    end
  end

`ifndef ASSERT_OFF
  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == B_FIN) |-> (pos < size))
    else $error("probe position beyond table size");
  a_probe_bound: assert property (@(posedge clk) disable iff (rst)
    (state == B_CHK) |-> (i < probes))
    else $error("probe count overrun");
  a_count_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (count >= $past(count)))
    else $error("stored count decreased");
  a_no_pop_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !pop && !out_valid)
    else $error("item taken during clearing pass");
`endif
endmodule

### rtl/core/quadratic_probe_hash_insert.sv
// Quadratic-probing hash table insert engine.
// Input channel: in_valid/in_stall with hash_value, item_key, item_value.
// Output channel: out_valid/out_stall with placed, slot_index, stored_count;
// exactly one result per accepted item, in order.
// Config: cfg_we writes cfg_data to register cfg_index (0 table_size,
// 1 key store enable); write only while the block is idle.
// The front takes an item and reduces the hash mod size with a one-bit-per-
// cycle remainder unit, then queues it (two entries). The back probes slot
// (base + i*i) mod size; each probe reads the registered status memory in a
// read state and a check state, then a finish state writes and posts the
// result. The front takes a new item once the last is pushed, overlapping
// the back while the queue has room; sustained rate is set by the longer
// of the remainder unit and the probe loop (up to (size+1)/2 probes).
// After reset a clearing pass empties all of the status memory; in_stall
// stays high during it. A stalled result holds in the output register; the
// front keeps taking items until the queue fills and it holds one more.
module quadratic_probe_hash_insert #(
  parameter int CAPACITY    = 1024,
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [qph_pkg::SZ_W-1:0]   cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [31:0]                hash_value,
  input  logic [31:0]                item_key,
  input  logic [31:0]                item_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       placed,
  output logic [qph_pkg::SLOT_W-1:0] slot_index,
  output logic [qph_pkg::SZ_W-1:0]   stored_count
);
  import qph_pkg::*;

  logic [SZ_W-1:0]  table_size;
  logic             key_store_en;
  logic             clearing;
  logic             push;
  logic             pop;
  logic             full;
  logic             empty;
  logic [ENT_W-1:0] wentry;
  logic [ENT_W-1:0] rentry;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size   <= SZ_W'(1021);
      key_store_en <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TABLE_SIZE: table_size   <= cfg_data;
        CFG_KEY_STORE:  key_store_en <= cfg_data[0];
        default: ;
      endcase
    end
  end

  qph_front #(.CAPACITY(CAPACITY)) u_front (
    .clk, .rst, .clearing, .table_size,
    .in_valid, .in_stall, .hash_value, .item_key, .item_value,
    .push, .entry(wentry), .full
  );

  qph_fifo #(.W(ENT_W)) u_fifo (
    .clk, .rst, .push, .wdata(wentry), .full,
    .pop, .rdata(rentry), .empty
  );

  qph_back #(
    .CAPACITY(CAPACITY), .KEY_WIDTH(KEY_WIDTH), .VALUE_WIDTH(VALUE_WIDTH)
  ) u_back (
    .clk, .rst, .clearing, .key_store_en,
    .entry(rentry), .empty, .pop,
    .out_valid, .out_stall, .placed, .slot_index, .stored_count
  );
endmodule
